FILE: rtl/mvsd_pkg.sv
`timescale 1ns / 1ps
package mvsd_pkg;

	typedef enum logic [2:0] {
		SEG_UNUSED   = 3'd0,
		SEG_MAPPED   = 3'd1,
		SEG_CACHED   = 3'd2,
		SEG_DIRECT   = 3'd3,
		SEG_CACHED32 = 3'd4,
		SEG_DIRECT32 = 3'd5
	} seg_kind_t;

	typedef enum logic [1:0] {
		ROUTE_ICACHE = 2'd0,
		ROUTE_DCACHE = 2'd1,
		ROUTE_BUS    = 2'd2,
		ROUTE_TLB    = 2'd3
	} route_t;

	typedef enum logic [1:0] {
		STATUS_OK        = 2'd0,
		STATUS_LOAD_ERR  = 2'd1,
		STATUS_STORE_ERR = 2'd2
	} status_t;

	localparam logic [1:0] MODE_FETCH = 2'd0;
	localparam logic [1:0] MODE_STORE = 2'd2;

	localparam logic [1:0] SIZE_WORD = 2'd2;

	localparam logic [3:0] CODE_DIRECT32     = 4'd5;
	localparam logic [3:0] CODE_KERNEL64     = 4'd6;
	localparam logic [3:0] CODE_SUPERVISOR64 = 4'd7;
	localparam logic [3:0] CODE_USER64       = 4'd8;

	localparam int unsigned ADDR_W = 4;
	localparam logic [1:0] REG_WIDE_ADDRESSING = 2'd0;
	localparam logic [1:0] REG_SEGMENT_TABLE   = 2'd1;
	localparam logic [1:0] REG_ADDRESS_ERRORS  = 2'd2;

	localparam logic [31:0] SEGMENT_TABLE_RESET = 32'h1132_1111;

endpackage

FILE: rtl/mvsd_acc_if.sv
`timescale 1ns / 1ps
interface mvsd_acc_if;
	logic        valid;
	logic        ready;
	logic [63:0] virtual_address;
	logic [1:0]  size_code;
	logic [1:0]  mode;
	logic        check_alignment;

	modport source (output valid, output virtual_address, output size_code, output mode,
		output check_alignment, input ready);
	modport sink (input valid, input virtual_address, input size_code, input mode,
		input check_alignment, output ready);
endinterface

FILE: rtl/mvsd_res_if.sv
`timescale 1ns / 1ps
interface mvsd_res_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [2:0]  segment_kind;
	logic [1:0]  route;
	logic [31:0] phys_address;
	logic [63:0] bad_vaddr;
	logic [1:0]  bad_region;
	logic [26:0] bad_vpn;

	modport source (output valid, output status, output segment_kind, output route,
		output phys_address, output bad_vaddr, output bad_region, output bad_vpn,
		input ready);
	modport sink (input valid, input status, input segment_kind, input route,
		input phys_address, input bad_vaddr, input bad_region, input bad_vpn,
		output ready);
endinterface

FILE: rtl/mips_virtual_segment_decoder_core.sv
`timescale 1ns / 1ps
// Decodes one MIPS virtual address per clock unless res stalls: a transfer on acc is
// answered by exactly one transfer on res, in order. The three pipeline stages check for
// address errors and read the segment table, then classify the address through the table
// and the 64-bit range chains, then form the route, physical address and bad-address
// fields; the last stage is the output register. A stall on res holds the whole pipeline
// and drops acc.ready only while the output register is full. The user must write the three
// configuration registers via the APB port while the block is idle; nothing enforces it.
module mips_virtual_segment_decoder_core (
	input  logic                           clk,
	input  logic                           arst_n,
	mvsd_acc_if.sink                       acc,
	mvsd_res_if.source                     res,
	input  logic                           psel,
	input  logic                           penable,
	input  logic                           pwrite,
	input  logic [mvsd_pkg::ADDR_W-1:0]    paddr,
	input  logic [31:0]                    pwdata,
	output logic [31:0]                    prdata,
	output logic                           pready
);
	import mvsd_pkg::*;

	logic        wide_q;
	logic [31:0] table_q;
	logic        aerr_on_q;

	logic        adv;
	logic        cfg_wr;
	logic [1:0]  reg_idx;

	logic        valid_s1;
	logic [63:0] va0_s1;
	logic [2:0]  va_lo_s1;
	logic        fetch_s1;
	logic        store_s1;
	logic        pre_err_s1;
	logic [3:0]  code_s1;

	logic        valid_s2;
	logic [63:0] va0_s2;
	logic [31:0] va_s2;
	logic        fetch_s2;
	logic        store_s2;
	logic        err_s2;
	seg_kind_t   kind_s2;

	logic        valid_s3;
	status_t     status_s3;
	seg_kind_t   kind_s3;
	route_t      route_s3;
	logic [31:0] phys_s3;
	logic [63:0] bad_vaddr_s3;

	logic        fetch_c;
	logic        store_c;
	logic [1:0]  size_c;
	logic [2:0]  mask_c;
	logic        checks_c;
	logic        misalign_c;
	logic        sext_bad_c;
	logic [3:0]  code_c;

	seg_kind_t   kernel_c;
	seg_kind_t   super_c;
	seg_kind_t   user_c;
	seg_kind_t   kind_c;
	logic        low_c;
	logic        xk_lo_c;

	status_t     status_c;
	route_t      route_c;
	logic [31:0] phys_c;

	assign pready  = 1'b1;
	assign reg_idx = paddr[ADDR_W-1:2];
	assign cfg_wr  = psel && penable && pwrite && pready;

	always_comb begin
		case (reg_idx)
			REG_WIDE_ADDRESSING: prdata = {31'd0, wide_q};
			REG_SEGMENT_TABLE:   prdata = table_q;
			REG_ADDRESS_ERRORS:  prdata = {31'd0, aerr_on_q};
			default:             prdata = 32'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wide_q    <= 1'b0;
			table_q   <= SEGMENT_TABLE_RESET;
			aerr_on_q <= 1'b1;
		end else if (cfg_wr) begin
			case (reg_idx)
				REG_WIDE_ADDRESSING: wide_q    <= pwdata[0];
				REG_SEGMENT_TABLE:   table_q   <= pwdata;
				REG_ADDRESS_ERRORS:  aerr_on_q <= pwdata[0];
				default:             ;
			endcase
		end
	end

	assign adv       = !valid_s3 || res.ready;
	assign acc.ready = adv;

	// Stage one: address error checks and segment table read.
	always_comb begin
		fetch_c    = (acc.mode == MODE_FETCH);
		store_c    = (acc.mode == MODE_STORE);
		size_c     = fetch_c ? SIZE_WORD : acc.size_code;
		mask_c     = 3'((4'd1 << size_c) - 4'd1);
		checks_c   = aerr_on_q && (!store_c || acc.check_alignment);
		misalign_c = |(acc.virtual_address[2:0] & mask_c);
		sext_bad_c = !wide_q && (acc.virtual_address[63:32] != {32{acc.virtual_address[31]}});
		code_c     = table_q[{acc.virtual_address[31:29], 2'b00} +: 4];
	end

	// Stage two: classification.
	always_comb begin
		low_c   = (va0_s1[63:40] == 24'h0);
		xk_lo_c = (va0_s1[63:40] == 24'h40_0000);

		if (low_c || xk_lo_c) begin
			kernel_c = SEG_MAPPED;
		end else if (va0_s1[63:62] == 2'b10) begin
			if (va0_s1[58:32] != 27'd0) begin
				kernel_c = SEG_UNUSED;
			end else if (va0_s1[61:59] == 3'b010) begin
				kernel_c = SEG_DIRECT32;
			end else begin
				kernel_c = SEG_CACHED32;
			end
		end else if (va0_s1[63:40] == 24'hc0_0000 && va0_s1[39:31] != 9'h1ff) begin
			kernel_c = SEG_MAPPED;
		end else if (va0_s1[63:31] == {33{1'b1}}) begin
			case (va0_s1[30:29])
				2'b00:   kernel_c = SEG_CACHED;
				2'b01:   kernel_c = SEG_DIRECT;
				default: kernel_c = SEG_MAPPED;
			endcase
		end else begin
			kernel_c = SEG_UNUSED;
		end

		if (low_c || xk_lo_c ||
				(va0_s1[63:32] == 32'hffff_ffff && va0_s1[31:29] == 3'b110)) begin
			super_c = SEG_MAPPED;
		end else begin
			super_c = SEG_UNUSED;
		end

		user_c = low_c ? SEG_MAPPED : SEG_UNUSED;

		if (code_s1 <= CODE_DIRECT32) begin
			kind_c = seg_kind_t'(code_s1[2:0]);
		end else if (!wide_q) begin
			kind_c = SEG_UNUSED;
		end else begin
			case (code_s1)
				CODE_KERNEL64:     kind_c = kernel_c;
				CODE_SUPERVISOR64: kind_c = super_c;
				CODE_USER64:       kind_c = user_c;
				default:           kind_c = SEG_UNUSED;
			endcase
		end
	end

	// Stage three: result formatting.
	always_comb begin
		route_c = ROUTE_BUS;
		phys_c  = 32'd0;
		case (kind_s2)
			SEG_MAPPED: begin
				route_c = ROUTE_TLB;
			end
			SEG_CACHED: begin
				route_c = fetch_s2 ? ROUTE_ICACHE : ROUTE_DCACHE;
				phys_c  = {3'd0, va_s2[28:0]};
			end
			SEG_DIRECT: begin
				phys_c = {3'd0, va_s2[28:0]};
			end
			SEG_CACHED32: begin
				route_c = fetch_s2 ? ROUTE_ICACHE : ROUTE_DCACHE;
				phys_c  = va_s2;
			end
			default: begin
				phys_c = va_s2;
			end
		endcase
		if (err_s2) begin
			status_c = store_s2 ? STATUS_STORE_ERR : STATUS_LOAD_ERR;
		end else begin
			status_c = STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= acc.valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			va0_s1     <= acc.virtual_address;
			va_lo_s1   <= store_c ? (acc.virtual_address[2:0] & ~mask_c)
				: acc.virtual_address[2:0];
			fetch_s1   <= fetch_c;
			store_s1   <= store_c;
			pre_err_s1 <= checks_c && (misalign_c || sext_bad_c);
			code_s1    <= code_c;

			va0_s2   <= va0_s1;
			va_s2    <= {va0_s1[31:3], va_lo_s1};
			fetch_s2 <= fetch_s1;
			store_s2 <= store_s1;
			err_s2   <= pre_err_s1 || (kind_c == SEG_UNUSED);
			kind_s2  <= pre_err_s1 ? SEG_UNUSED : kind_c;

			status_s3    <= status_c;
			kind_s3      <= err_s2 ? SEG_UNUSED : kind_s2;
			route_s3     <= err_s2 ? ROUTE_ICACHE : route_c;
			phys_s3      <= err_s2 ? 32'd0 : phys_c;
			bad_vaddr_s3 <= err_s2 ? va0_s2 : 64'd0;
		end
	end

	assign res.valid        = valid_s3;
	assign res.status       = status_s3;
	assign res.segment_kind = kind_s3;
	assign res.route        = route_s3;
	assign res.phys_address = phys_s3;
	assign res.bad_vaddr    = bad_vaddr_s3;
	assign res.bad_region   = bad_vaddr_s3[63:62];
	assign res.bad_vpn      = bad_vaddr_s3[39:13];

`ifndef SYNTHESIS
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && status_s3 != STATUS_OK) |->
			(kind_s3 == SEG_UNUSED && route_s3 == ROUTE_ICACHE && phys_s3 == 32'd0))
		else $error("Error result carries a segment, route or physical address.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && status_s3 == STATUS_OK) |->
			(bad_vaddr_s3 == 64'd0 && kind_s3 != SEG_UNUSED))
		else $error("Good result carries bad-address fields or an unused segment.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s3 && status_s3 == STATUS_OK && kind_s3 == SEG_MAPPED) |->
			(route_s3 == ROUTE_TLB && phys_s3 == 32'd0))
		else $error("Mapped segment not sent to the TLB.");

	assert property (@(posedge clk) disable iff (!arst_n)
		(adv && valid_s2) |=> valid_s3)
		else $error("Transfer lost between the second and third stages.");
`endif

endmodule
